// ===== sv/prs80_pkg.sv =====
`default_nettype none

package prs80_pkg;

  localparam int PRS80_ROUNDS = 31;
  localparam int BLOCK_W      = 64;
  localparam int KEY_W        = 80;
  localparam int KEY_LOW_W    = 64;
  localparam int KEY_HIGH_W   = 16;
  localparam int RC_W         = 5;
  localparam int CFG_IDX_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(1);

  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] state;
    logic [KEY_W-1:0]   key;
  } prs80_stage_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      r[4*n +: 4] = sbox(s[4*n +: 4]);
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    for (int i = 0; i < BLOCK_W - 1; i++) begin
      r[(16 * i) % (BLOCK_W - 1)] = s[i];
    end
    r[BLOCK_W-1] = s[BLOCK_W-1];
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] subkey_bits(input logic [KEY_W-1:0] k);
    return k[KEY_W-1 -: BLOCK_W];
  endfunction

endpackage

`default_nettype wire

// ===== sv/prs80_round_cell.sv =====
`default_nettype none

module prs80_round_cell
  import prs80_pkg::*;
#(
  parameter logic [RC_W-1:0] ROUND = RC_W'(1)
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire prs80_stage_t din,
  output prs80_stage_t      dout
);

  logic [BLOCK_W-1:0] state_next;
  logic [KEY_W-1:0]   key_rot;
  logic [KEY_W-1:0]   key_next;

  always_comb begin
    state_next = perm_layer(sub_layer(din.state ^ subkey_bits(din.key)));
    key_rot    = {din.key[18:0], din.key[KEY_W-1:19]};
    key_next   = key_rot;
    key_next[KEY_W-1 -: 4] = sbox(key_rot[KEY_W-1 -: 4]);
    key_next[19:15] = key_rot[19:15] ^ ROUND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.state <= state_next;
    dout.key   <= key_next;
  end

endmodule

`default_nettype wire

// ===== sv/prs80_out_stage.sv =====
`default_nettype none

module prs80_out_stage
  import prs80_pkg::*;
#(
  parameter bit WHITEN = 1'b1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire prs80_stage_t din,
  output logic              done,
  output logic [BLOCK_W-1:0] ciphertext
);

  logic [BLOCK_W-1:0] ciphertext_next;

  always_comb begin
    if (WHITEN) begin
      ciphertext_next = din.state ^ subkey_bits(din.key);
    end else begin
      ciphertext_next = din.state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= din.valid;
    end
    ciphertext <= ciphertext_next;
  end

endmodule

`default_nettype wire

// ===== sv/present80_block_encrypt.sv =====
`default_nettype none

// Channel     Direction  Handshake           Payload
// block in    input      start & !busy       plaintext[63:0]
// block out   output     done (one cycle)    ciphertext[63:0]
// key write   input      cfg_wr_en           cfg_index, cfg_wdata
//
// One block enters every cycle; busy is never raised.
// Each block passes one round cell per round, then the output register,
// which applies the final key XOR when NUM_ROUNDS equals PRS80_ROUNDS.
// Synchronous reset clears the key registers and all valid flags.
// The receiver cannot stall: each result shows for one cycle with done.

module present80_block_encrypt
  import prs80_pkg::*;
#(
  parameter int NUM_ROUNDS = PRS80_ROUNDS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [BLOCK_W-1:0]   plaintext,
  output logic                      done,
  output logic [BLOCK_W-1:0]        ciphertext,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_LOW_W-1:0] cfg_wdata
);

  logic [KEY_LOW_W-1:0]  key_low;
  logic [KEY_HIGH_W-1:0] key_high;
  prs80_stage_t          chain [NUM_ROUNDS+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low  <= cfg_wdata;
        CFG_KEY_HIGH: key_high <= cfg_wdata[KEY_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  assign chain[0].valid = start && !busy;
  assign chain[0].state = plaintext;
  assign chain[0].key   = {key_high, key_low};

  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
    prs80_round_cell #(
      .ROUND (RC_W'(g + 1))
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  prs80_out_stage #(
    .WHITEN (NUM_ROUNDS == PRS80_ROUNDS)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .din        (chain[NUM_ROUNDS]),
    .done       (done),
    .ciphertext (ciphertext)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(NUM_ROUNDS + 1) done)
    else $error("transaction result missing at expected latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(chain[NUM_ROUNDS].valid))
    else $error("result strobe without transaction in last cell");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import prs80_pkg::*;

  localparam int ROUNDS = PRS80_ROUNDS;
  localparam int LATENCY = ROUNDS + 1;
  localparam int WATCHDOG_LIMIT = 600;
  localparam int PHASES = 6;
  localparam int BLOCKS_PER_PHASE = 240;
  localparam logic [63:0] SBOX_NIBBLES = 64'h2174_8FE3_DA09_B65C;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [BLOCK_W-1:0]   plaintext = '0;
  logic                 done;
  logic [BLOCK_W-1:0]   ciphertext;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_LOW_W-1:0] cfg_wdata = '0;

  logic [KEY_LOW_W-1:0]  key_low_q = '0;
  logic [KEY_HIGH_W-1:0] key_high_q = '0;
  logic [BLOCK_W-1:0]    pending_ciphertexts[$];
  int                    error_count = 0;
  int                    idle_cycles = 0;
  int                    burst_left = 1;

  present80_block_encrypt dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .plaintext  (plaintext),
    .done       (done),
    .ciphertext (ciphertext),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [3:0] sbox_lookup(input logic [3:0] x);
    return SBOX_NIBBLES[4*x +: 4];
  endfunction

  function automatic logic [BLOCK_W-1:0] present80_encrypt(input logic [BLOCK_W-1:0] pt,
                                                            input logic [KEY_W-1:0] key);
    logic [BLOCK_W-1:0] st;
    logic [BLOCK_W-1:0] sub;
    logic [BLOCK_W-1:0] prm;
    logic [KEY_W-1:0]   k;
    logic [RC_W-1:0]    rc_bits;
    st = pt;
    k = key;
    for (int rc = 1; rc <= ROUNDS; rc++) begin
      st = st ^ k[79:16];
      for (int n = 0; n < 16; n++) begin
        sub[4*n +: 4] = sbox_lookup(st[4*n +: 4]);
      end
      for (int i = 0; i < 63; i++) begin
        prm[(16 * i) % 63] = sub[i];
      end
      prm[63] = sub[63];
      st = prm;
      k = {k[18:0], k[79:19]};
      k[79:76] = sbox_lookup(k[79:76]);
      rc_bits = rc[RC_W-1:0];
      k[19:15] = k[19:15] ^ rc_bits;
    end
    if (ROUNDS == 31) begin
      st = st ^ k[79:16];
    end
    return st;
  endfunction

  function automatic logic [BLOCK_W-1:0] random_block();
    logic [BLOCK_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: begin
        v = 64'h1 << $urandom_range(0, 63);
      end
      1: begin
        v = ~(64'h1 << $urandom_range(0, 63));
      end
      2: begin
        v = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  task automatic send_block(input logic [BLOCK_W-1:0] pt);
    start <= 1'b1;
    plaintext <= pt;
    do @(posedge clk); while (busy);
    pending_ciphertexts.push_back(present80_encrypt(pt, {key_high_q, key_low_q}));
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
  endtask

  // hold off new blocks until every expected ciphertext has come out
  task automatic flush_pipeline();
    start <= 1'b0;
    do @(posedge clk); while (pending_ciphertexts.size() != 0);
  endtask

  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_LOW_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_KEY_LOW) begin
      key_low_q = data;
    end else if (idx == CFG_KEY_HIGH) begin
      key_high_q = data[KEY_HIGH_W-1:0];
    end
  endtask

  task automatic load_key(input logic [KEY_LOW_W-1:0] lo, input logic [KEY_LOW_W-1:0] hi);
    flush_pipeline();
    write_key_reg(CFG_KEY_LOW, lo);
    write_key_reg(CFG_KEY_HIGH, hi);
  endtask

  task automatic test_reset_key();
    send_block('0);
    send_block('1);
    send_block(64'hAAAA_AAAA_AAAA_AAAA);
    send_block(64'h5555_5555_5555_5555);
    send_block(64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_key_extremes();
    load_key('1, 64'hFFFF);
    send_block('0);
    send_block('1);
    send_block(64'h8000_0000_0000_0001);
    load_key('0, 64'hFFFF);
    send_block('0);
    load_key('1, '0);
    send_block('1);
  endtask

  task automatic test_key_register_writes();
    logic [CFG_IDX_W-1:0] stray_idx;
    load_key(64'hDEAD_BEEF_0BAD_F00D, 64'h1234);
    stray_idx = CFG_IDX_W'($urandom_range(2, 255));
    write_key_reg(stray_idx, {$urandom, $urandom});
    write_key_reg('1, {$urandom, $urandom});
    send_block(64'hFEDC_BA98_7654_3210);
    send_block('0);
    flush_pipeline();
    write_key_reg(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_0000 | 64'hA5C3);
    send_block('1);
    send_block(64'h0F0F_0F0F_F0F0_F0F0);
  endtask

  task automatic test_random_blocks();
    logic [KEY_LOW_W-1:0] lo;
    logic [KEY_LOW_W-1:0] hi;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          lo = '0;
          hi = '0;
        end
        1: begin
          lo = '1;
          hi = '1;
        end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase
      load_key(lo, hi);
      if ($urandom_range(0, 1)) begin
        write_key_reg(CFG_IDX_W'($urandom_range(2, 255)), {$urandom, $urandom});
      end
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        send_block(random_block());
        if (p == 2 && n == BLOCKS_PER_PHASE / 2) begin
          flush_pipeline();
        end
      end
    end
  endtask

  always @(posedge clk) begin
    logic [BLOCK_W-1:0] exp_ct;
    if (!rst && done) begin
      if (pending_ciphertexts.size() == 0) begin
        $error("unexpected ciphertext %h", ciphertext);
        error_count++;
      end else begin
        exp_ct = pending_ciphertexts.pop_front();
        if (ciphertext !== exp_ct) begin
          $error("ciphertext mismatch: expected %h, actual %h", exp_ct, ciphertext);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("present80_block_encrypt verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_key();
    test_key_extremes();
    test_key_register_writes();
    test_random_blocks();
    flush_pipeline();
    repeat (LATENCY + 8) @(posedge clk);
    if (pending_ciphertexts.size() != 0) begin
      $error("%0d ciphertexts never arrived", pending_ciphertexts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("present80_block_encrypt verification clean");
    end else begin
      $display("present80_block_encrypt verification failed");
    end
    $finish;
  end

endmodule
